>>> design/link_failover_selector_macros.svh
// Assertion macros used by the checker file of the link failover selector.
`ifndef LINK_FAILOVER_SELECTOR_MACROS_SVH
`define LINK_FAILOVER_SELECTOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define LFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfs assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define LFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfs assertion failed");

`endif

>>> design/lfs_pkg.sv
// Types and constants of the link failover selector.
package lfs_pkg;

  localparam int AGE_W      = 17;
  localparam int HOLD_W     = 16;
  localparam int CFG_ADDR_W = 3;

  localparam logic [AGE_W-1:0] AGE_MAX = 17'h1FFFF;

  // Link states, ordered worst to best.
  localparam logic [1:0] ST_INVALID = 2'd0;
  localparam logic [1:0] ST_DOWN    = 2'd1;
  localparam logic [1:0] ST_UP      = 2'd2;
  localparam logic [1:0] ST_RUNNING = 2'd3;

  // Register select bit (paddr[2]).
  localparam logic REG_LINK_COUNT = 1'b0;
  localparam logic REG_HOLD_OFF   = 1'b1;

  localparam logic [2:0]        LINK_COUNT_RST = 3'd2;
  localparam logic [HOLD_W-1:0] HOLD_OFF_RST   = 16'd10000;

  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_SELECT = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } lfs_op_t;

  // Command from the sequencer to the link table.
  typedef struct packed {
    logic       wr;         // store a new state at the addressed slot
    logic       leave_run;  // slot leaves running: set was_running, restart age
    logic       tick;       // age every slot by one
    logic [1:0] state;
  } lfs_tbl_cmd_t;

  // Read port of the link table.
  typedef struct packed {
    logic [1:0]       state;
    logic             was_run;
    logic [AGE_W-1:0] age;
  } lfs_tbl_rd_t;

endpackage

>>> design/lfs_if.sv
// Item channels of the link failover selector: command in, result out.
interface lfs_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [1:0] link_index;
  logic [1:0] link_state;

  modport source (output valid, output operation, output link_index, output link_state,
                  input ready);
  modport sink   (input valid, input operation, input link_index, input link_state,
                  output ready);
endinterface

interface lfs_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] selected_link;
  logic       selection_valid;
  logic       use_default;
  logic       selection_changed;
  logic       link_state_changed;
  logic       recheck_scheduled;

  modport source (output valid, output selected_link, output selection_valid,
                  output use_default, output selection_changed,
                  output link_state_changed, output recheck_scheduled, input ready);
  modport sink   (input valid, input selected_link, input selection_valid,
                  input use_default, input selection_changed,
                  input link_state_changed, input recheck_scheduled, output ready);
endinterface

>>> design/link_failover_selector.sv
// Top level of the link failover selector: sequencer, registers and ports.
//
// Channel  Dir  Handshake         Payload
// cmd      in   valid/ready       operation, link_index, link_state
// rsp      out  valid/ready       selected_link, selection_valid, use_default,
//                                 selection_changed, link_state_changed,
//                                 recheck_scheduled
// apb      in   psel/penable      link_count (0x0), hold_off_ticks (0x4)
//
// A report, tick or no-op item passes through S_EXEC and S_DONE before the next accept,
// and so does a select that needs no scan.
// A select that scans adds S_SCAN, stepping one link slot at a time through the
// single table read port and the shared compare unit, then S_DECIDE.
// cmd.ready is high only while the sequencer is idle; one finished result can
// wait in the output register while the next item is taken in.
// A stalled output holds the sequencer in its final step until the register frees.
// Reset (rst, synchronous) clears all links to invalid and arms a reselection.
module link_failover_selector import lfs_pkg::*; #(
  parameter int NUM_LINKS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  lfs_cmd_if.sink               cmd,
  lfs_rsp_if.source             rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int SLOT_W = $clog2(NUM_LINKS);
  localparam int CNT_W  = $clog2(NUM_LINKS + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DECIDE = 5'b01000,
    S_DONE   = 5'b10000
  } lfs_state_t;

  lfs_state_t state;

  // Configuration registers.
  logic [2:0]        link_count;
  logic [HOLD_W-1:0] hold_off;

  // Latched item.
  lfs_op_t    op_q;
  logic [1:0] idx_q;
  logic [1:0] st_q;

  // Selection state.
  logic [SLOT_W-1:0] cur;
  logic              cur_valid;
  logic              reselect;
  logic [HOLD_W-1:0] recheck_cnt;
  logic              recheck_armed;

  // Scan state.
  logic [SLOT_W-1:0] scan_i;
  logic [SLOT_W-1:0] best;
  logic [1:0]        best_state;
  logic              have_best;

  // Result flags of the item in flight.
  logic f_changed;
  logic f_lsc;
  logic f_rsched;

  logic rsp_valid;

  logic              cfg_wr;
  logic [CNT_W-1:0]  eff_cnt;
  logic              cur_in_range;
  logic              idx_in_range;
  logic              sel_cv;
  logic              report_hit;
  logic              scan_start;
  logic              scan_take;
  logic              scan_last;
  logic [HOLD_W-1:0] cnt_dec;

  lfs_tbl_cmd_t      tbl_cmd;
  lfs_tbl_rd_t       tbl_rd;
  logic [SLOT_W-1:0] tbl_addr;

  logic              cmp_gt;
  logic              cmp_hold;
  logic [HOLD_W-1:0] cmp_delay;

  // ---------------------------------------------------------------- config port
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_LINK_COUNT: prdata = {29'd0, link_count};
      REG_HOLD_OFF:   prdata = {16'd0, hold_off};
      default:        prdata = '0;
    endcase
  end

  // Link count clamped to the slots that exist.
  always_comb begin
    if (32'(link_count) > NUM_LINKS) begin
      eff_cnt = CNT_W'(NUM_LINKS);
    end else begin
      eff_cnt = CNT_W'(link_count);
    end
  end

  assign cur_in_range = 32'(cur) < 32'(eff_cnt);
  assign idx_in_range = (32'(idx_q) < 32'(eff_cnt)) && (32'(idx_q) < NUM_LINKS);
  assign sel_cv       = cur_valid && cur_in_range;

  // ---------------------------------------------------------------- link table
  always_comb begin
    unique case (state)
      S_EXEC:  tbl_addr = (op_q == OP_REPORT) ? SLOT_W'(32'(idx_q)) : cur;
      S_SCAN:  tbl_addr = scan_i;
      default: tbl_addr = cur;
    endcase
  end

  assign report_hit = (state == S_EXEC) && (op_q == OP_REPORT) && idx_in_range &&
                      (tbl_rd.state != st_q);

  always_comb begin
    tbl_cmd.wr        = report_hit;
    tbl_cmd.leave_run = (tbl_rd.state == ST_RUNNING) && (st_q != ST_RUNNING);
    tbl_cmd.tick      = (state == S_EXEC) && (op_q == OP_TICK);
    tbl_cmd.state     = st_q;
  end

  lfs_link_table #(.NUM_LINKS(NUM_LINKS)) u_table (
    .clk  (clk),
    .rst  (rst),
    .cmd  (tbl_cmd),
    .addr (tbl_addr),
    .rd   (tbl_rd)
  );

  // ---------------------------------------------------------------- shared compare
  lfs_cmp_unit u_cmp (
    .cand_state  (tbl_rd.state),
    .best_state  (best_state),
    .hold        (hold_off),
    .age         (tbl_rd.age),
    .gt          (cmp_gt),
    .hold_active (cmp_hold),
    .delay       (cmp_delay)
  );

  // A select of two or more links scans on reselect or an invalid current, unless a running current is kept.
  assign scan_start = (op_q == OP_SELECT) && (eff_cnt > CNT_W'(1)) &&
                      (reselect || !sel_cv) &&
                      !(sel_cv && (tbl_rd.state == ST_RUNNING));

  // Skip the current link; take a slot only if strictly better than the best so far (ties keep the earlier).
  assign scan_take = !(cur_valid && (scan_i == cur)) && (!have_best || cmp_gt);
  assign scan_last = 32'(scan_i) == (32'(eff_cnt) - 1);
  assign cnt_dec   = (recheck_cnt != '0) ? recheck_cnt - 1'b1 : recheck_cnt;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      link_count    <= LINK_COUNT_RST;
      hold_off      <= HOLD_OFF_RST;
      cur           <= '0;
      cur_valid     <= 1'b0;
      reselect      <= 1'b1;
      recheck_cnt   <= '0;
      recheck_armed <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_LINK_COUNT: link_count <= pwdata[2:0];
          REG_HOLD_OFF:   hold_off   <= pwdata[HOLD_W-1:0];
          default: ;
        endcase
      end

      // Drop the result once taken, unless a new one is loaded below.
      if (rsp_valid && rsp.ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op_q      <= lfs_op_t'(cmd.operation);
            idx_q     <= cmd.link_index;
            st_q      <= cmd.link_state;
            f_changed <= 1'b0;
            f_lsc     <= 1'b0;
            f_rsched  <= 1'b0;
            state     <= S_EXEC;
          end
        end

        S_EXEC: begin
          state <= scan_start ? S_SCAN : S_DONE;
          unique case (op_q)
            OP_REPORT: begin
              if (report_hit) begin
                reselect <= 1'b1;
                f_lsc    <= 1'b1;
              end
            end
            OP_TICK: begin
              if (recheck_armed) begin
                recheck_cnt <= cnt_dec;
                if (cnt_dec == '0) begin
                  recheck_armed <= 1'b0;
                  reselect      <= 1'b1;
                end
              end
            end
            OP_SELECT: begin
              if (eff_cnt == '0) begin
                reselect <= 1'b0;
              end else if (eff_cnt == CNT_W'(1)) begin
                // Single link: pin slot zero.
                f_changed <= !cur_valid || (cur != '0);
                cur       <= '0;
                cur_valid <= 1'b1;
                reselect  <= 1'b0;
              end else begin
                cur_valid <= sel_cv;
                if (reselect || !sel_cv) begin
                  reselect <= 1'b0;
                  // Keep a running current link; otherwise scan the slots below the link count.
                  if (!(sel_cv && (tbl_rd.state == ST_RUNNING))) begin
                    have_best  <= sel_cv;
                    best       <= cur;
                    best_state <= ST_INVALID;
                    scan_i     <= '0;
                  end
                end
              end
            end
            default: ;
          endcase
        end

        S_SCAN: begin
          if (scan_take) begin
            have_best  <= 1'b1;
            best       <= scan_i;
            best_state <= tbl_rd.state;
          end
          scan_i <= scan_i + 1'b1;
          if (scan_last) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          state <= S_DONE;
          priority if (cur_valid && ((best == cur) || (best_state != ST_RUNNING))) begin
            // Nothing better and running: keep current.
          end else if (cur_valid && tbl_rd.was_run && cmp_hold) begin
            // Current left running too recently: defer, keep earliest expiry.
            if (!recheck_armed || (cmp_delay < recheck_cnt)) begin
              recheck_cnt <= cmp_delay;
            end
            recheck_armed <= 1'b1;
            f_rsched      <= 1'b1;
          end else begin
            cur       <= best;
            cur_valid <= 1'b1;
            f_changed <= !cur_valid || (cur != best);
          end
        end

        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid                <= 1'b1;
            rsp.use_default          <= (eff_cnt == '0);
            rsp.selected_link        <= (eff_cnt == '0) ? 2'd0 : 2'(32'(cur));
            rsp.selection_valid      <= (eff_cnt == '0) ? 1'b1 : cur_valid;
            rsp.selection_changed    <= f_changed;
            rsp.link_state_changed   <= f_lsc;
            rsp.recheck_scheduled    <= f_rsched;
            state                    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign cmd.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;

endmodule

>>> design/lfs_link_table.sv
// Per-link state, was-running flag and saturating age, one read/write slot.
module lfs_link_table import lfs_pkg::*; #(
  parameter int NUM_LINKS = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lfs_tbl_cmd_t                 cmd,
  input  logic [$clog2(NUM_LINKS)-1:0] addr,
  output lfs_tbl_rd_t                  rd
);

  logic [1:0]       states  [NUM_LINKS];
  logic             was_run [NUM_LINKS];
  logic [AGE_W-1:0] age     [NUM_LINKS];

  assign rd.state   = states[addr];
  assign rd.was_run = was_run[addr];
  assign rd.age     = age[addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LINKS; i++) begin
        states[i]  <= ST_INVALID;
        was_run[i] <= 1'b0;
        age[i]     <= '0;
      end
    end else begin
      if (cmd.tick) begin
        for (int i = 0; i < NUM_LINKS; i++) begin
          if (age[i] != AGE_MAX) begin
            age[i] <= age[i] + 1'b1;
          end
        end
      end
      if (cmd.wr) begin
        states[addr] <= cmd.state;
        if (cmd.leave_run) begin
          was_run[addr] <= 1'b1;
          age[addr]     <= '0;
        end
      end
    end
  end

endmodule

>>> design/lfs_cmp_unit.sv
// Shared compare unit: candidate-vs-best state and hold-off age test.
module lfs_cmp_unit import lfs_pkg::*; (
  input  logic [1:0]        cand_state,
  input  logic [1:0]        best_state,
  input  logic [HOLD_W-1:0] hold,
  input  logic [AGE_W-1:0]  age,
  output logic              gt,
  output logic              hold_active,
  output logic [HOLD_W-1:0] delay
);

  logic [AGE_W:0] diff;

  assign gt          = cand_state > best_state;
  // Borrow in the top bit means age is past the hold-off.
  assign diff        = {2'b00, hold} - {1'b0, age};
  assign hold_active = !diff[AGE_W] && (diff != '0);
  assign delay       = diff[HOLD_W-1:0];

endmodule

>>> design/lfs_checker.sv
// Port-level checker for the link failover selector, bound to the top level.
`include "link_failover_selector_macros.svh"

module lfs_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] selected_link,
  input logic       selection_valid,
  input logic       use_default,
  input logic       selection_changed,
  input logic       link_state_changed,
  input logic       recheck_scheduled
);

  logic [2:0] flags;
  logic [6:0] payload;

  assign flags   = {selection_changed, link_state_changed, recheck_scheduled};
  assign payload = {selected_link, selection_valid, use_default, flags};

  // A stalled result holds.
  `LFS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(payload))
  // Busy right after taking an item.
  `LFS_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready)
  // One item changes at most one kind of thing.
  `LFS_ASSERT_NOW(a_one_flag, rsp_valid, $onehot0(flags))
  // Default link shows slot zero, valid, and no selection activity.
  `LFS_ASSERT_NOW(a_default_view, rsp_valid && use_default,
                  selection_valid && (selected_link == 2'd0) && !selection_changed &&
                  !recheck_scheduled)

endmodule

bind link_failover_selector lfs_checker u_lfs_checker (
  .clk                (clk),
  .rst                (rst),
  .cmd_valid          (cmd.valid),
  .cmd_ready          (cmd.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .selected_link      (rsp.selected_link),
  .selection_valid    (rsp.selection_valid),
  .use_default        (rsp.use_default),
  .selection_changed  (rsp.selection_changed),
  .link_state_changed (rsp.link_state_changed),
  .recheck_scheduled  (rsp.recheck_scheduled)
);
